// ===== sv/mase_pkg.sv =====
`timescale 1ns / 1ps
package mase_pkg;

   localparam int MAX_DIM_DEF   = 8;
   localparam int ELEM_BITS_DEF = 16;

   localparam int VALUE_BITS     = 16;
   localparam int IDX_BITS       = 3;
   localparam int CMD_BITS       = 2;
   localparam int MODE_BITS      = 2;
   localparam int DIM_BITS       = 4;
   localparam int RES_BITS       = 40;
   localparam int FRAC_BITS      = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 4;
   localparam int REQ_DATA_BITS  = 24;
   localparam int RSP_DATA_BITS  = 48;

   localparam logic [CMD_BITS-1:0] CMD_LOAD_A = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_LOAD_B = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_START  = 2'd2;

   localparam logic [MODE_BITS-1:0] MODE_ADD = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SUB = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MUL = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_OP_MODE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROWS_A  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLS_A  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROWS_B  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLS_B  = 3'd4;

   typedef struct packed {
      logic en;
      logic first;
      logic mul;
      logic sub;
   } mac_ctrl_type;

endpackage

// ===== sv/mase_ram.sv =====
`timescale 1ns / 1ps
module mase_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mase_mac.sv =====
`timescale 1ns / 1ps
module mase_mac #(
   parameter int ELEM_BITS = mase_pkg::ELEM_BITS_DEF
) (
   input  logic                              clock,
   input  mase_pkg::mac_ctrl_type            ctrl,
   input  logic signed [ELEM_BITS-1:0]       a_data,
   input  logic signed [ELEM_BITS-1:0]       b_data,
   output logic signed [mase_pkg::RES_BITS-1:0] acc
);

   localparam int ProdW = 2 * ELEM_BITS;
   localparam int WideW = (ProdW > mase_pkg::RES_BITS) ? ProdW : mase_pkg::RES_BITS;

   logic signed [ProdW-1:0]              prod;
   logic signed [ELEM_BITS:0]            sum;
   logic signed [WideW-1:0]              prod_w;
   logic signed [WideW-1:0]              sum_w;
   logic signed [mase_pkg::RES_BITS-1:0] term;
   logic signed [mase_pkg::RES_BITS-1:0] acc_in;
   logic signed [mase_pkg::RES_BITS-1:0] acc_ff;

   always_comb begin
      prod   = a_data * b_data;
      sum    = ctrl.sub ? ((ELEM_BITS + 1)'(a_data) - (ELEM_BITS + 1)'(b_data))
                        : ((ELEM_BITS + 1)'(a_data) + (ELEM_BITS + 1)'(b_data));
      prod_w = WideW'(prod);
      sum_w  = WideW'(sum) <<< mase_pkg::FRAC_BITS;
      term   = ctrl.mul ? prod_w[mase_pkg::RES_BITS-1:0] : sum_w[mase_pkg::RES_BITS-1:0];
      acc_in = ctrl.first ? term : acc_ff + term;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== sv/matrix_add_sub_mul_engine_unit.sv =====
`timescale 1ns / 1ps
// Matrix add, subtract and multiply engine. Load transfers (cmd 0 for A, cmd 1 for B) write
// one element each; an unused command is accepted and does nothing. A start transfer (cmd 2)
// runs the operation chosen by op_mode over the sizes in the dimension registers and sends
// the result elements in row-major order, the final one with rsp_tlast set. The block takes
// no request until the final result has been transferred. Each result element is built by
// the single multiply-accumulate unit, which takes one operand pair per cycle from the
// registered read ports of the two element stores: cols_a pairs for a multiply and one
// pair for add or subtract. After a wait state for the registered read, the element is
// offered and held until rsp_tready. A dimension mismatch yields one error result.
module matrix_add_sub_mul_engine_unit #(
   parameter int MAX_DIM   = mase_pkg::MAX_DIM_DEF,
   parameter int ELEM_BITS = mase_pkg::ELEM_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // cmd[1:0], row[4:2], col[7:5], value[23:8]
   input  logic [mase_pkg::REQ_DATA_BITS-1:0]      req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // out_row[2:0], out_col[5:3], result[45:6], zero fill[47:46]
   output logic [mase_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                                    rsp_tlast,
   // dims_error
   output logic                                    rsp_tuser,
   input  logic                                    csr_wen,
   input  logic [mase_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mase_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int IdxW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int Depth = MAX_DIM * MAX_DIM;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int DimW  = mase_pkg::DIM_BITS;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CALC = 4'b0010,
      S_WAIT = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [mase_pkg::MODE_BITS-1:0] op_mode_ff;
   logic [DimW-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;

   logic [IdxW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic            err_ff, err_in;
   logic            rd_valid_ff, rd_valid_in;
   logic            rd_first_ff, rd_first_in;

   logic [mase_pkg::CMD_BITS-1:0]          req_cmd;
   logic [mase_pkg::IDX_BITS-1:0]          req_row, req_col;
   logic signed [mase_pkg::VALUE_BITS-1:0] req_value;
   logic                                   req_xfer;
   logic                                   ld_in_range;
   logic                                   wr_a, wr_b;
   logic [AddrW-1:0]                       wr_addr;
   logic [ELEM_BITS-1:0]                   wr_data;

   logic [AddrW-1:0]              a_raddr, b_raddr;
   logic signed [ELEM_BITS-1:0]   a_rdata, b_rdata;
   logic signed [mase_pkg::RES_BITS-1:0] acc;
   mase_pkg::mac_ctrl_type        mac_ctrl;

   logic            is_mul;
   logic [DimW-1:0] n_cols;
   logic            dims_ok;
   logic            k_last, i_last, j_last;
   logic [mase_pkg::RES_BITS-1:0] out_result;

   assign req_cmd   = req_tdata[1:0];
   assign req_row   = req_tdata[4:2];
   assign req_col   = req_tdata[7:5];
   assign req_value = req_tdata[23:8];

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   assign ld_in_range = (DimW'(req_row) < DimW'(MAX_DIM)) && (DimW'(req_col) < DimW'(MAX_DIM));
   assign wr_a    = req_xfer && ld_in_range && (req_cmd == mase_pkg::CMD_LOAD_A);
   assign wr_b    = req_xfer && ld_in_range && (req_cmd == mase_pkg::CMD_LOAD_B);
   assign wr_addr = AddrW'(int'(req_row) * MAX_DIM + int'(req_col));
   assign wr_data = ELEM_BITS'(req_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff <= mase_pkg::MODE_ADD;
         rows_a_ff  <= DimW'(1);
         cols_a_ff  <= DimW'(1);
         rows_b_ff  <= DimW'(1);
         cols_b_ff  <= DimW'(1);
      end else if (csr_wen) begin
         case (csr_index)
            mase_pkg::CSR_OP_MODE: op_mode_ff <= csr_wdata[mase_pkg::MODE_BITS-1:0];
            mase_pkg::CSR_ROWS_A:  rows_a_ff  <= csr_wdata;
            mase_pkg::CSR_COLS_A:  cols_a_ff  <= csr_wdata;
            mase_pkg::CSR_ROWS_B:  rows_b_ff  <= csr_wdata;
            mase_pkg::CSR_COLS_B:  cols_b_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   function automatic logic dim_ok(input logic [mase_pkg::DIM_BITS-1:0] d);
      dim_ok = (d != '0) && (d <= mase_pkg::DIM_BITS'(MAX_DIM));
   endfunction

   always_comb begin
      is_mul = (op_mode_ff == mase_pkg::MODE_MUL);
      n_cols = is_mul ? cols_b_ff : cols_a_ff;
      case (op_mode_ff)
         mase_pkg::MODE_ADD, mase_pkg::MODE_SUB:
            dims_ok = dim_ok(rows_a_ff) && dim_ok(cols_a_ff) &&
                      (rows_a_ff == rows_b_ff) && (cols_a_ff == cols_b_ff);
         mase_pkg::MODE_MUL:
            dims_ok = dim_ok(rows_a_ff) && dim_ok(cols_a_ff) && dim_ok(cols_b_ff) &&
                      (cols_a_ff == rows_b_ff);
         default: dims_ok = 1'b0;
      endcase
      k_last = !is_mul || (DimW'(k_ff) + DimW'(1) == cols_a_ff);
      i_last = (DimW'(i_ff) + DimW'(1) == rows_a_ff);
      j_last = (DimW'(j_ff) + DimW'(1) == n_cols);
      a_raddr = is_mul ? AddrW'(int'(i_ff) * MAX_DIM + int'(k_ff))
                       : AddrW'(int'(i_ff) * MAX_DIM + int'(j_ff));
      b_raddr = is_mul ? AddrW'(int'(k_ff) * MAX_DIM + int'(j_ff))
                       : AddrW'(int'(i_ff) * MAX_DIM + int'(j_ff));
   end

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      err_in      = err_ff;
      rd_valid_in = 1'b0;
      rd_first_in = (k_ff == '0);
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_cmd == mase_pkg::CMD_START)) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               err_in   = !dims_ok;
               state_in = dims_ok ? S_CALC : S_EMIT;
            end
         end
         S_CALC: begin
            rd_valid_in = 1'b1;
            if (k_last) begin
               state_in = S_WAIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_WAIT: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_tready) begin
               if (rsp_tlast) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = '0;
                  state_in = S_CALC;
                  if (j_last) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_valid_ff <= 1'b0;
         i_ff        <= '0;
         j_ff        <= '0;
         k_ff        <= '0;
         err_ff      <= 1'b0;
         rd_first_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         k_ff        <= k_in;
         err_ff      <= err_in;
         rd_first_ff <= rd_first_in;
      end
   end

   mase_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (Depth)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   mase_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (Depth)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   assign mac_ctrl.en    = rd_valid_ff;
   assign mac_ctrl.first = rd_first_ff;
   assign mac_ctrl.mul   = is_mul;
   assign mac_ctrl.sub   = (op_mode_ff == mase_pkg::MODE_SUB);

   mase_mac #(
      .ELEM_BITS (ELEM_BITS)
   ) u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .a_data (a_rdata),
      .b_data (b_rdata),
      .acc    (acc)
   );

   assign out_result = err_ff ? '0 : acc;
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tlast  = err_ff || (i_last && j_last);
   assign rsp_tuser  = err_ff;
   assign rsp_tdata  = {2'b00, out_result,
                        mase_pkg::IDX_BITS'(j_ff), mase_pkg::IDX_BITS'(i_ff)};

endmodule

// ===== sv/mase_checker.sv =====
`timescale 1ns / 1ps
module mase_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [mase_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [mase_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                               rsp_tlast,
   input logic                               rsp_tuser
);

   // The engine works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a result is pending");

   // An error result is a single, final, all-zero element.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("malformed dimension error result");

   // After a start transfer the engine stops accepting requests.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[1:0] == mase_pkg::CMD_START) |=> !req_tready)
      else $error("start transfer did not begin a run");

   // After the final result transfers, the engine returns to accepting requests.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("engine not ready after the final result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind matrix_add_sub_mul_engine_unit mase_checker u_mase_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
